// File: hdl/ste_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ste_pkg
// Shared constants and types for the sine tone generator.
// ----------------------------------------------------------------------------
package ste_pkg;

	localparam int unsigned SAMPLE_RATE_DEF = 44100;
	localparam int unsigned SAMPLE_BITS_DEF = 16;

	localparam int unsigned IDX_W    = 26;
	localparam int unsigned FREQ_W   = 16;
	localparam int unsigned SECS_W   = 10;
	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned ADDR_W   = 3;
	localparam int unsigned DATA_W   = 32;

	localparam logic REG_TONE_FREQUENCY = 1'b0;
	localparam logic REG_TONE_SECONDS   = 1'b1;

	localparam logic [FREQ_W-1:0] FREQ_RESET = 16'd440;
	localparam logic [SECS_W-1:0] SECS_RESET = 10'd1;

	typedef struct packed {
		logic valid;
		logic neg;
		logic last;
	} ste_tag_t;

endpackage

// File: hdl/ste_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ste_regs
// APB register file: tone frequency and duration, with the derived phase
// step and total sample count kept alongside.
// ----------------------------------------------------------------------------
module ste_regs import ste_pkg::*; #(
	parameter int unsigned SAMPLE_RATE = SAMPLE_RATE_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [ADDR_W-1:0]              paddr,
	input  logic [DATA_W-1:0]              pwdata,
	output logic [DATA_W-1:0]              prdata,
	output logic                           pready,
	output logic [$clog2(SAMPLE_RATE)-1:0] step,
	output logic [IDX_W-1:0]               total
);

	localparam int unsigned PW   = $clog2(SAMPLE_RATE);
	localparam int unsigned QMAX = ((1 << FREQ_W) - 1) / SAMPLE_RATE;
	localparam int unsigned QW   = $clog2(QMAX + 1);
	localparam int unsigned RW   = FREQ_W + 4;

	localparam logic [PW-1:0]    STEP_RESET  = PW'(FREQ_RESET % SAMPLE_RATE);
	localparam logic [IDX_W-1:0] TOTAL_RESET = IDX_W'(SECS_RESET * SAMPLE_RATE);

	logic [FREQ_W-1:0] freq_q;
	logic [SECS_W-1:0] secs_q;
	logic [PW-1:0]     step_q;
	logic [IDX_W-1:0]  total_q;

	logic              wr;
	logic [FREQ_W-1:0] wfreq;
	logic [SECS_W-1:0] wsecs;
	logic [QW-1:0]     quot;
	logic [RW-1:0]     rem;
	logic [IDX_W-1:0]  total_nxt;

	assign wr    = psel & penable & pwrite;
	assign wfreq = pwdata[FREQ_W-1:0];
	assign wsecs = pwdata[SECS_W-1:0];

	// quotient by parallel compares against multiples of the rate
	always_comb begin
		quot = '0;
		for (int k = 1; k <= int'(QMAX); k++) begin
			if (RW'(wfreq) >= RW'(k * SAMPLE_RATE))
				quot = QW'(k);
		end
		rem = RW'(wfreq) - RW'(quot) * RW'(SAMPLE_RATE);
	end

	assign total_nxt = IDX_W'(wsecs) * IDX_W'(SAMPLE_RATE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q  <= FREQ_RESET;
			secs_q  <= SECS_RESET;
			step_q  <= STEP_RESET;
			total_q <= TOTAL_RESET;
		end else if (wr) begin
			unique case (paddr[2])
				REG_TONE_FREQUENCY: begin
					freq_q <= wfreq;
					step_q <= rem[PW-1:0];
				end
				REG_TONE_SECONDS: begin
					secs_q  <= wsecs;
					total_q <= total_nxt;
				end
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			REG_TONE_FREQUENCY: prdata = DATA_W'(freq_q);
			REG_TONE_SECONDS:   prdata = DATA_W'(secs_q);
		endcase
	end

	assign pready = 1'b1;
	assign step   = step_q;
	assign total  = total_q;

endmodule

// File: hdl/ste_phase.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ste_phase
// Phase remainder and sample index state; folds the phase into a quarter
// wave and registers the table index for stage one.
// ----------------------------------------------------------------------------
module ste_phase import ste_pkg::*; #(
	parameter int unsigned SAMPLE_RATE = SAMPLE_RATE_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             accept,
	input  logic                             restart,
	input  logic                             en,
	input  logic [$clog2(SAMPLE_RATE)-1:0]   step,
	input  logic [IDX_W-1:0]                 total,
	output logic [$clog2(SAMPLE_RATE+1)-1:0] m_s1,
	output ste_tag_t                         tag_s1
);

	localparam int unsigned PW = $clog2(SAMPLE_RATE);
	localparam int unsigned MW = $clog2(SAMPLE_RATE + 1);
	localparam int unsigned QW = PW + 2;

	localparam logic [QW-1:0] N1 = QW'(SAMPLE_RATE);
	localparam logic [QW-1:0] N2 = QW'(2 * SAMPLE_RATE);
	localparam logic [QW-1:0] N3 = QW'(3 * SAMPLE_RATE);
	localparam logic [QW-1:0] N4 = QW'(4 * SAMPLE_RATE);

	logic [PW-1:0]    phase_q;
	logic [IDX_W-1:0] index_q;
	logic             done_q;

	logic [PW-1:0]    ph0;
	logic [IDX_W-1:0] ix0;
	logic             dn0;
	logic             produce;
	logic             last;
	logic [QW-1:0]    q;
	logic [QW-1:0]    m_full;
	logic             neg;
	logic [PW:0]      psum;
	logic [PW-1:0]    ph_nxt;

	assign ph0 = restart ? '0 : phase_q;
	assign ix0 = restart ? '0 : index_q;
	assign dn0 = restart ? 1'b0 : done_q;

	assign produce = !dn0 && (ix0 < total);
	assign last    = (ix0 == total - IDX_W'(1));

	assign q = {ph0, 2'b00};

	always_comb begin
		if (q <= N1) begin
			m_full = q;
			neg    = 1'b0;
		end else if (q <= N2) begin
			m_full = N2 - q;
			neg    = 1'b0;
		end else if (q <= N3) begin
			m_full = q - N2;
			neg    = 1'b1;
		end else begin
			m_full = N4 - q;
			neg    = 1'b1;
		end
	end

	assign psum   = {1'b0, ph0} + {1'b0, step};
	assign ph_nxt = (psum >= (PW+1)'(SAMPLE_RATE)) ?
		PW'(psum - (PW+1)'(SAMPLE_RATE)) : psum[PW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			index_q <= '0;
			done_q  <= 1'b0;
		end else if (accept) begin
			if (produce) begin
				phase_q <= ph_nxt;
				index_q <= ix0 + IDX_W'(1);
				done_q  <= last;
			end else begin
				phase_q <= ph0;
				index_q <= ix0;
				done_q  <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else if (en) begin
			tag_s1.valid <= accept & produce;
			tag_s1.neg   <= neg;
			tag_s1.last  <= last;
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			m_s1 <= m_full[MW-1:0];
	end

endmodule

// File: hdl/ste_sine_rom.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ste_sine_rom
// Quarter-wave sine magnitude table, filled at start-up from a Q30
// Taylor series, with registered read.
// ----------------------------------------------------------------------------
module ste_sine_rom import ste_pkg::*; #(
	parameter int unsigned SAMPLE_RATE = SAMPLE_RATE_DEF,
	parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  logic [$clog2(SAMPLE_RATE+1)-1:0] m_s1,
	input  ste_tag_t                         tag_s1,
	output logic [SAMPLE_W-1:0]              mag_s2,
	output ste_tag_t                         tag_s2
);

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
	localparam logic [63:0] AMPLITUDE   = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
	localparam logic [63:0] RATE        = 64'(SAMPLE_RATE);

	logic [SAMPLE_W-1:0] sine_rom [0:SAMPLE_RATE];

	function automatic logic [SAMPLE_W-1:0] quarter_mag(input int unsigned m);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		longint      sum;
		logic [63:0] mag;
		x    = (HALF_PI_Q30 * 64'(m)) / RATE;
		x2   = (x * x) >> 30;
		term = x;
		sum  = longint'(x);
		for (int k = 1; k <= 7; k++) begin
			term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
			if (k % 2 == 1)
				sum = sum - longint'(term);
			else
				sum = sum + longint'(term);
		end
		if (sum < 0)
			sum = 0;
		if (64'(sum) > Q30_ONE)
			sum = longint'(Q30_ONE);
		mag = (AMPLITUDE * 64'(sum)) >> 30;
		if (mag > AMPLITUDE)
			mag = AMPLITUDE;
		return mag[SAMPLE_W-1:0];
	endfunction

	initial begin
		for (int i = 0; i <= int'(SAMPLE_RATE); i++)
			sine_rom[i] = quarter_mag(i);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tag_s2 <= '0;
		else if (en)
			tag_s2 <= tag_s1;
	end

	always_ff @(posedge clk) begin
		if (en)
			mag_s2 <= sine_rom[m_s1];
	end

endmodule

// File: hdl/sine_tone_generator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sine_tone_generator_top
// Pipeline from tick transfer to sample_valid: phase, table read and
// sign/output registers. Throughput: one tick per cycle unless stalled,
// set by the phase add and one table read per cycle.
// Reset: phase, index and done flag cleared; 440 Hz, 1 second.
// ----------------------------------------------------------------------------
module sine_tone_generator_top import ste_pkg::*; #(
	parameter int unsigned SAMPLE_RATE = SAMPLE_RATE_DEF,
	parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [DATA_W-1:0]   pwdata,
	output logic [DATA_W-1:0]   prdata,
	output logic                pready,
	input  logic                tick_valid,
	output logic                tick_stall,
	input  logic                restart,
	output logic                sample_valid,
	input  logic                sample_stall,
	output logic signed [SAMPLE_W-1:0] sample_value,
	output logic                last_sample
);

	localparam int unsigned PW = $clog2(SAMPLE_RATE);
	localparam int unsigned MW = $clog2(SAMPLE_RATE + 1);

	logic [PW-1:0]       step;
	logic [IDX_W-1:0]    total;
	logic [MW-1:0]       m_s1;
	ste_tag_t            tag_s1;
	logic [SAMPLE_W-1:0] mag_s2;
	ste_tag_t            tag_s2;

	logic en_out;
	logic en_s2;
	logic en_s1;
	logic accept;

	logic                valid_q;
	logic                last_q;
	logic [SAMPLE_W-1:0] value_q;

	assign en_out     = !valid_q || !sample_stall;
	assign en_s2      = !tag_s2.valid || en_out;
	assign en_s1      = !tag_s1.valid || en_s2;
	assign tick_stall = !en_s1;
	assign accept     = tick_valid && en_s1;

	ste_regs #(
		.SAMPLE_RATE(SAMPLE_RATE)
	) u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.step   (step),
		.total  (total)
	);

	ste_phase #(
		.SAMPLE_RATE(SAMPLE_RATE)
	) u_phase (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.restart(restart),
		.en     (en_s1),
		.step   (step),
		.total  (total),
		.m_s1   (m_s1),
		.tag_s1 (tag_s1)
	);

	ste_sine_rom #(
		.SAMPLE_RATE(SAMPLE_RATE),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_rom (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (en_s2),
		.m_s1  (m_s1),
		.tag_s1(tag_s1),
		.mag_s2(mag_s2),
		.tag_s2(tag_s2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (en_out)
			valid_q <= tag_s2.valid;
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			value_q <= tag_s2.neg ? (SAMPLE_W'(0) - mag_s2) : mag_s2;
			last_q  <= tag_s2.last;
		end
	end

	assign sample_valid = valid_q;
	assign sample_value = value_q;
	assign last_sample  = last_q;

endmodule
